>>> hdl/swdt_pkg.sv
package swdt_pkg;

  localparam int unsigned DataBits = 33;
  localparam int unsigned CntW     = 9;
  localparam int unsigned HdrBits  = 8;
  localparam int unsigned AckBits  = 3;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_HEADER    = 4'd1;
  localparam logic [3:0] PH_TRN_ACK   = 4'd2;
  localparam logic [3:0] PH_ACK       = 4'd3;
  localparam logic [3:0] PH_RDATA     = 4'd4;
  localparam logic [3:0] PH_TRN_RD    = 4'd5;
  localparam logic [3:0] PH_TRN_WR    = 4'd6;
  localparam logic [3:0] PH_WDATA     = 4'd7;
  localparam logic [3:0] PH_IDLECYC   = 4'd8;
  localparam logic [3:0] PH_WF_DREAD  = 4'd9;
  localparam logic [3:0] PH_WF_TRN    = 4'd10;
  localparam logic [3:0] PH_WF_DWRITE = 4'd11;
  localparam logic [3:0] PH_BACKOFF   = 4'd12;

  localparam logic       CMD_START = 1'b0;

  localparam logic [1:0] REG_TURNAROUND = 2'd0;
  localparam logic [1:0] REG_IDLE       = 2'd1;
  localparam logic [1:0] REG_FORCE      = 2'd2;

  localparam logic [2:0] ACK_OK    = 3'd1;
  localparam logic [2:0] ACK_WAIT  = 3'd2;
  localparam logic [2:0] ACK_FAULT = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_FAULT  = 3'd2;
  localparam logic [2:0] ST_PROTO  = 3'd3;
  localparam logic [2:0] ST_PARITY = 3'd4;

  typedef struct packed {
    logic [2:0] turnaround;
    logic [7:0] idle;
    logic       force_data;
  } cfg_t;

  typedef struct packed {
    logic [3:0]          phase;
    logic [CntW-1:0]     cnt;
    logic [DataBits-1:0] shift;
    logic [3:0]          req;
    logic [2:0]          ack;
    logic                par;
  } state_t;

  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        transfer_done;
    logic [2:0]  status;
    logic [31:0] read_word;
  } result_t;

  function automatic logic [CntW-1:0] trn_len(input logic [2:0] t);
    logic [CntW-1:0] r;
    if (t == 3'd0) begin
      r = CntW'(1);
    end else if (t > 3'd4) begin
      r = CntW'(4);
    end else begin
      r = CntW'(t);
    end
    return r;
  endfunction

endpackage

>>> hdl/swd_transfer_master.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-------------------------------------------
// in       | input     | in_valid_i/in_ready_o   | cmd, request_bits, wr_word, swdio_sample
// out      | output    | out_valid_o/out_ready_i | drive_enable, drive_level, transfer_done,
//          |           |                         | status, read_word
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index (0..2), cfg_data
//
// An item is held in the input register, and the step logic's result for it is loaded into
// the result register, from which it is offered, once the output is free or taking it.
// One item per cycle while the output does not stall.
// Start items and ticks while idle give no result and retire without touching the output.
// A stalled output holds its result; the input stage still takes one more item behind it.
// Reset clears the transfer state and both valid flags and sets the config to its defaults.
module swd_transfer_master import swdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [3:0]  request_bits_i,
  input  logic [31:0] wr_word_i,
  input  logic        swdio_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        drive_enable_o,
  output logic        drive_level_o,
  output logic        transfer_done_o,
  output logic [2:0]  status_o,
  output logic [31:0] read_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t        cfg_q;
  state_t      st_q, st_d;
  result_t     res_d, res_q;
  logic        res_vld;
  logic        in_valid_q;
  logic        cmd_q;
  logic [3:0]  req_q;
  logic [31:0] wdata_q;
  logic        sample_q;
  logic        out_valid_q;
  logic        adv;
  logic        emit;

  swdt_step u_step (
    .st_i           (st_q),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd_q),
    .request_bits_i (req_q),
    .wr_word_i      (wdata_q),
    .swdio_sample_i (sample_q),
    .st_o           (st_d),
    .res_o          (res_d),
    .res_valid_o    (res_vld)
  );

  assign adv        = in_valid_q && (!res_vld || !out_valid_q || out_ready_i);
  assign emit       = adv && res_vld;
  assign in_ready_o = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{turnaround: 3'd1, idle: 8'd0, force_data: 1'b0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TURNAROUND: cfg_q.turnaround <= cfg_data_i[2:0];
        REG_IDLE:       cfg_q.idle       <= cfg_data_i;
        REG_FORCE:      cfg_q.force_data <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        st_q <= st_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      req_q    <= request_bits_i;
      wdata_q  <= wr_word_i;
      sample_q <= swdio_sample_i;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_enable_o  = res_q.drive_enable;
  assign drive_level_o   = res_q.drive_level;
  assign transfer_done_o = res_q.transfer_done;
  assign status_o        = res_q.status;
  assign read_word_o     = res_q.read_word;

  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !transfer_done_o |-> status_o == ST_OK && read_word_o == '0)
    else $error("status or read word outside final cycle");

  a_level_needs_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_enable_o || !drive_level_o)
    else $error("level driven while not enabled");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res_d.transfer_done |=> st_q.phase == PH_IDLE)
    else $error("phase not idle after done");

  a_idle_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && cmd_q != CMD_START && st_q.phase == PH_IDLE |-> !res_vld)
    else $error("tick while idle gave a result");

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && cmd_q == CMD_START |=> st_q.phase == PH_HEADER && st_q.cnt == '0)
    else $error("start did not enter header");

endmodule

>>> hdl/swdt_step.sv
module swdt_step import swdt_pkg::*; (
  input  state_t      st_i,
  input  cfg_t        cfg_i,
  input  logic        cmd_i,
  input  logic [3:0]  request_bits_i,
  input  logic [31:0] wr_word_i,
  input  logic        swdio_sample_i,
  output state_t      st_o,
  output result_t     res_o,
  output logic        res_valid_o
);

  logic [CntW-1:0]    cnt_nx;
  logic [CntW-1:0]    tl;
  logic [HdrBits-1:0] hdr;
  logic [2:0]         ack_nx;
  logic               rd;
  logic               ok_end;
  logic               in_data;

  assign cnt_nx  = st_i.cnt + CntW'(1);
  assign tl      = trn_len(cfg_i.turnaround);
  assign hdr     = {1'b1, 1'b0, ^st_i.req, st_i.req, 1'b1};
  assign rd      = st_i.req[1];
  assign in_data = st_i.cnt < CntW'(DataBits);

  always_comb begin
    st_o        = st_i;
    res_o       = '0;
    res_valid_o = 1'b0;
    ok_end      = 1'b0;
    ack_nx      = st_i.ack;
    if (cmd_i == CMD_START) begin
      st_o.req   = request_bits_i;
      st_o.shift = {^wr_word_i, wr_word_i};
      st_o.ack   = '0;
      st_o.par   = 1'b0;
      st_o.cnt   = '0;
      st_o.phase = PH_HEADER;
    end else begin
      res_valid_o = 1'b1;
      st_o.cnt    = cnt_nx;
      case (st_i.phase)
        PH_HEADER: begin
          res_o.drive_enable = 1'b1;
          res_o.drive_level  = hdr[st_i.cnt[2:0]];
          if (cnt_nx >= CntW'(HdrBits)) begin
            st_o.phase = PH_TRN_ACK;
            st_o.cnt   = '0;
          end
        end
        PH_TRN_ACK: begin
          if (cnt_nx >= tl) begin
            st_o.phase = PH_ACK;
            st_o.cnt   = '0;
          end
        end
        PH_ACK: begin
          if (st_i.cnt[1:0] != 2'd3) begin
            ack_nx[st_i.cnt[1:0]] = st_i.ack[st_i.cnt[1:0]] | swdio_sample_i;
          end
          st_o.ack = ack_nx;
          if (cnt_nx >= CntW'(AckBits)) begin
            st_o.cnt = '0;
            if (ack_nx == ACK_OK) begin
              if (rd) begin
                st_o.shift = '0;
                st_o.par   = 1'b0;
                st_o.phase = PH_RDATA;
              end else begin
                st_o.phase = PH_TRN_WR;
              end
            end else if (ack_nx == ACK_WAIT || ack_nx == ACK_FAULT) begin
              st_o.phase = (cfg_i.force_data && rd) ? PH_WF_DREAD : PH_WF_TRN;
            end else begin
              st_o.phase = PH_BACKOFF;
            end
          end
        end
        PH_RDATA: begin
          if (in_data) begin
            st_o.shift[st_i.cnt[5:0]] = st_i.shift[st_i.cnt[5:0]] | swdio_sample_i;
          end
          st_o.par = st_i.par ^ swdio_sample_i;
          if (cnt_nx >= CntW'(DataBits)) begin
            st_o.phase = PH_TRN_RD;
            st_o.cnt   = '0;
          end
        end
        PH_TRN_RD: begin
          if (cnt_nx >= tl) begin
            st_o.cnt = '0;
            if (cfg_i.idle == 8'd0) begin
              ok_end = 1'b1;
            end else begin
              st_o.phase = PH_IDLECYC;
            end
          end
        end
        PH_TRN_WR: begin
          if (cnt_nx >= tl) begin
            st_o.phase = PH_WDATA;
            st_o.cnt   = '0;
          end
        end
        PH_WDATA: begin
          res_o.drive_enable = 1'b1;
          res_o.drive_level  = in_data & st_i.shift[st_i.cnt[5:0]];
          if (cnt_nx >= CntW'(DataBits)) begin
            st_o.cnt = '0;
            if (cfg_i.idle == 8'd0) begin
              ok_end = 1'b1;
            end else begin
              st_o.phase = PH_IDLECYC;
            end
          end
        end
        PH_IDLECYC: begin
          res_o.drive_enable = 1'b1;
          if (cnt_nx >= CntW'(cfg_i.idle)) begin
            st_o.cnt = '0;
            ok_end   = 1'b1;
          end
        end
        PH_WF_DREAD: begin
          if (cnt_nx >= CntW'(DataBits)) begin
            st_o.phase = PH_WF_TRN;
            st_o.cnt   = '0;
          end
        end
        PH_WF_TRN: begin
          if (cnt_nx >= tl) begin
            st_o.cnt = '0;
            if (cfg_i.force_data && !rd) begin
              st_o.phase = PH_WF_DWRITE;
            end else begin
              res_o.transfer_done = 1'b1;
              res_o.status        = (st_i.ack == ACK_WAIT) ? ST_WAIT : ST_FAULT;
              st_o.phase          = PH_IDLE;
            end
          end
        end
        PH_WF_DWRITE: begin
          res_o.drive_enable = 1'b1;
          if (cnt_nx >= CntW'(DataBits)) begin
            st_o.cnt            = '0;
            res_o.transfer_done = 1'b1;
            res_o.status        = (st_i.ack == ACK_WAIT) ? ST_WAIT : ST_FAULT;
            st_o.phase          = PH_IDLE;
          end
        end
        PH_BACKOFF: begin
          if (cnt_nx >= tl + CntW'(DataBits)) begin
            st_o.cnt            = '0;
            res_o.transfer_done = 1'b1;
            res_o.status        = ST_PROTO;
            st_o.phase          = PH_IDLE;
          end
        end
        default: begin
          res_valid_o = 1'b0;
          st_o.phase  = PH_IDLE;
          st_o.cnt    = '0;
        end
      endcase
      if (ok_end) begin
        res_o.transfer_done = 1'b1;
        st_o.phase          = PH_IDLE;
        if (rd) begin
          res_o.status    = st_i.par ? ST_PARITY : ST_OK;
          res_o.read_word = st_o.shift[31:0];
        end
      end
    end
  end

endmodule

>>> dv/swd_transfer_master_tb.sv
module swd_transfer_master_tb import swdt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       CMD_TICK   = ~CMD_START;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;

  localparam logic [2:0] PLAN_TRN   [0:7] = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd3, 3'd5, 3'd6};
  localparam logic [7:0] PLAN_IDLE  [0:7] = '{8'd0, 8'd255, 8'd1, 8'd5, 8'd0, 8'd0, 8'd2, 8'd0};
  localparam logic       PLAN_FORCE [0:7] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam int unsigned PLAN_ITEMS [0:7] = '{160, 220, 160, 140, 140, 140, 120, 100};

  class swdio_tracker;
    logic [2:0]  trn_q;
    logic [7:0]  idle_q;
    logic        force_q;
    logic [3:0]  ph;
    logic [8:0]  cnt;
    logic [32:0] shreg;
    logic [3:0]  req_q;
    logic [2:0]  ack_q;
    logic        par_q;
    result_t     exp_cycles[$];
    int unsigned bad;

    function new();
      trn_q   = 3'd1;
      idle_q  = 8'd0;
      force_q = 1'b0;
      ph      = PH_IDLE;
      cnt     = '0;
      shreg   = '0;
      req_q   = '0;
      ack_q   = '0;
      par_q   = 1'b0;
      bad     = 0;
    endfunction

    function int unsigned pending();
      return exp_cycles.size();
    endfunction

    function logic [8:0] turn_len();
      if (trn_q == 3'd0) return 9'd1;
      if (trn_q > 3'd4) return 9'd4;
      return 9'(trn_q);
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        REG_TURNAROUND: trn_q = v[2:0];
        REG_IDLE:       idle_q = v;
        REG_FORCE:      force_q = v[0];
        default: ;
      endcase
    endfunction

    function void note_item(logic c, logic [3:0] r, logic [31:0] w, logic s);
      result_t    res;
      logic [7:0] hdr;
      logic       ok_end;
      logic       is_rd;
      res    = '0;
      ok_end = 1'b0;
      if (c == CMD_START) begin
        req_q = r;
        shreg = {^w, w};
        ack_q = '0;
        par_q = 1'b0;
        cnt   = '0;
        ph    = PH_HEADER;
        return;
      end
      is_rd = req_q[1];
      case (ph)
        PH_HEADER: begin
          hdr = {1'b1, 1'b0, ^req_q, req_q, 1'b1};
          res.drive_enable = 1'b1;
          res.drive_level  = hdr[cnt[2:0]];
          cnt++;
          if (cnt >= 9'd8) begin
            ph  = PH_TRN_ACK;
            cnt = '0;
          end
        end
        PH_TRN_ACK: begin
          cnt++;
          if (cnt >= turn_len()) begin
            ph  = PH_ACK;
            cnt = '0;
          end
        end
        PH_ACK: begin
          ack_q = ack_q | (3'(s) << cnt[1:0]);
          cnt++;
          if (cnt >= 9'd3) begin
            cnt = '0;
            if (ack_q == ACK_OK) begin
              if (is_rd) begin
                shreg = '0;
                par_q = 1'b0;
                ph    = PH_RDATA;
              end else begin
                ph = PH_TRN_WR;
              end
            end else if (ack_q == ACK_WAIT || ack_q == ACK_FAULT) begin
              ph = (force_q && is_rd) ? PH_WF_DREAD : PH_WF_TRN;
            end else begin
              ph = PH_BACKOFF;
            end
          end
        end
        PH_RDATA: begin
          shreg[cnt[5:0]] = shreg[cnt[5:0]] | s;
          par_q = par_q ^ s;
          cnt++;
          if (cnt >= 9'd33) begin
            ph  = PH_TRN_RD;
            cnt = '0;
          end
        end
        PH_TRN_RD: begin
          cnt++;
          if (cnt >= turn_len()) begin
            cnt = '0;
            if (idle_q == 8'd0) ok_end = 1'b1;
            else ph = PH_IDLECYC;
          end
        end
        PH_TRN_WR: begin
          cnt++;
          if (cnt >= turn_len()) begin
            ph  = PH_WDATA;
            cnt = '0;
          end
        end
        PH_WDATA: begin
          res.drive_enable = 1'b1;
          res.drive_level  = shreg[cnt[5:0]];
          cnt++;
          if (cnt >= 9'd33) begin
            cnt = '0;
            if (idle_q == 8'd0) ok_end = 1'b1;
            else ph = PH_IDLECYC;
          end
        end
        PH_IDLECYC: begin
          res.drive_enable = 1'b1;
          cnt++;
          if (cnt >= 9'(idle_q)) begin
            cnt    = '0;
            ok_end = 1'b1;
          end
        end
        PH_WF_DREAD: begin
          cnt++;
          if (cnt >= 9'd33) begin
            ph  = PH_WF_TRN;
            cnt = '0;
          end
        end
        PH_WF_TRN: begin
          cnt++;
          if (cnt >= turn_len()) begin
            cnt = '0;
            if (force_q && !is_rd) begin
              ph = PH_WF_DWRITE;
            end else begin
              res.transfer_done = 1'b1;
              res.status        = (ack_q == ACK_WAIT) ? ST_WAIT : ST_FAULT;
              ph                = PH_IDLE;
            end
          end
        end
        PH_WF_DWRITE: begin
          res.drive_enable = 1'b1;
          cnt++;
          if (cnt >= 9'd33) begin
            cnt               = '0;
            res.transfer_done = 1'b1;
            res.status        = (ack_q == ACK_WAIT) ? ST_WAIT : ST_FAULT;
            ph                = PH_IDLE;
          end
        end
        PH_BACKOFF: begin
          cnt++;
          if (cnt >= turn_len() + 9'd33) begin
            cnt               = '0;
            res.transfer_done = 1'b1;
            res.status        = ST_PROTO;
            ph                = PH_IDLE;
          end
        end
        default: begin
          ph  = PH_IDLE;
          cnt = '0;
          return;
        end
      endcase
      if (ok_end) begin
        res.transfer_done = 1'b1;
        ph = PH_IDLE;
        if (is_rd) begin
          res.status    = par_q ? ST_PARITY : ST_OK;
          res.read_word = shreg[31:0];
        end
      end
      exp_cycles.push_back(res);
    endfunction

    function void check_cycle(result_t got);
      result_t want;
      if (exp_cycles.size() == 0) begin
        bad++;
        if (bad <= 10) $display("unexpected cycle result: %p", got);
        return;
      end
      want = exp_cycles.pop_front();
      if (got.drive_enable !== want.drive_enable || got.drive_level !== want.drive_level ||
          got.transfer_done !== want.transfer_done || got.status !== want.status ||
          got.read_word !== want.read_word) begin
        bad++;
        if (bad <= 10)
          $display("mismatch (exp/got): de %b/%b dl %b/%b done %b/%b st %0d/%0d rd %h/%h",
                   want.drive_enable, got.drive_enable, want.drive_level, got.drive_level,
                   want.transfer_done, got.transfer_done, want.status, got.status,
                   want.read_word, got.read_word);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        cmd_i          = CMD_TICK;
  logic [3:0]  request_bits_i = '0;
  logic [31:0] wr_word_i      = '0;
  logic        swdio_sample_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        drive_enable_o;
  logic        drive_level_o;
  logic        transfer_done_o;
  logic [2:0]  status_o;
  logic [31:0] read_word_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = '0;
  logic [7:0]  cfg_data_i     = '0;

  swdio_tracker sb = new();
  int unsigned  items_sent  = 0;
  int unsigned  cycles      = 0;
  bit           tx_calm     = 1'b0;
  bit           rx_calm     = 1'b0;
  bit           rx_hold_req = 1'b0;

  swd_transfer_master dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .request_bits_i,
    .wr_word_i,
    .swdio_sample_i,
    .out_valid_o,
    .out_ready_i,
    .drive_enable_o,
    .drive_level_o,
    .transfer_done_o,
    .status_o,
    .read_word_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_item(logic c, logic [3:0] r, logic [31:0] w, logic s);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    request_bits_i <= r;
    wr_word_i      <= w;
    swdio_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    if (c == CMD_START || sb.ph != PH_IDLE) items_sent++;
    sb.note_item(c, r, w, s);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop_at > 0 stops the ticks after stop_at of them; an unfinished transfer is aborted by the next start
  task automatic run_transfer(logic [3:0] r, logic [31:0] w, logic [2:0] a,
                              int unsigned stop_at);
    int unsigned n;
    logic        s;
    n = 0;
    send_item(CMD_START, r, w, 1'($urandom_range(0, 1)));
    do begin
      s = (sb.ph == PH_ACK) ? a[sb.cnt[1:0]] : 1'($urandom_range(0, 1));
      send_item(CMD_TICK, 4'($urandom_range(0, 15)), $urandom, s);
      n++;
    end while (sb.ph != PH_IDLE && n != stop_at);
  endtask

  task automatic random_transfer();
    int unsigned k;
    logic [2:0]  a;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      a = ACK_OK;
    end else if (k < 60) begin
      a = ACK_WAIT;
    end else if (k < 80) begin
      a = ACK_FAULT;
    end else begin
      a = 3'($urandom_range(0, 7));
      while (a == ACK_OK || a == ACK_WAIT || a == ACK_FAULT) a = 3'($urandom_range(0, 7));
    end
    if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
    run_transfer(4'($urandom_range(0, 15)), $urandom, a,
                 ($urandom_range(0, 11) == 0) ? $urandom_range(1, 60) : 0);
    if (sb.ph == PH_IDLE && $urandom_range(0, 7) == 0)
      send_item(CMD_TICK, 4'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = 150;
      end else if (stall == 0 && !rx_calm) begin
        stall = pick_gap();
      end
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      out_ready_i <= (stall == 0);
      if (stall != 0) stall--;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_cycle('{drive_enable_o, drive_level_o, transfer_done_o, status_o, read_word_o});
    end
  end

  initial begin
    int unsigned budget;
    bit          hold_done;
    bit          pause_done;
    logic [7:0]  idle_v;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ticks while idle are dropped
    send_item(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_TICK, 4'h0, 32'h0000_0000, 1'b0);
    run_transfer(4'hF, 32'hFFFF_FFFF, ACK_OK, 5);
    run_transfer(4'h0, 32'h0000_0000, ACK_WAIT, 0);

    for (int p = 0; p < 8; p++) begin
      drain();
      idle_v = (p == 5) ? 8'($urandom_range(0, 20)) : PLAN_IDLE[p];
      write_reg(REG_TURNAROUND, {5'($urandom), PLAN_TRN[p]});
      write_reg(REG_IDLE, idle_v);
      write_reg(REG_FORCE, {7'($urandom), (p == 5) ? 1'($urandom) : PLAN_FORCE[p]});
      if (p == 2) write_reg(REG_UNUSED, 8'($urandom));
      budget = items_sent + PLAN_ITEMS[p];
      while (items_sent < budget) begin
        random_transfer();
        if (!hold_done && items_sent >= 100) begin
          hold_done   = 1'b1;
          rx_hold_req = 1'b1;
        end
        if (!pause_done && items_sent >= 700) begin
          pause_done = 1'b1;
          drain();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.bad == 0 && sb.pending() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
